// ===== rtl/core/tkl_pkg.sv =====
// ----------------------------------------------------------------------------
// tkl_pkg
// Shared widths, node record layouts, control word format and the
// microprogram of the trie key lookup unit.
// ----------------------------------------------------------------------------
package tkl_pkg;

  // Node store geometry
  localparam int unsigned NODE_COUNT = 65536;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned INFO_W     = 24;

  // Upper bound on nodes visited by one sibling walk
  localparam int unsigned WALK_LIMIT = 65536;
  localparam int unsigned STEP_W     = $clog2(WALK_LIMIT);

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_KEY   = 1'b1;

  // Link record of one node
  typedef struct packed {
    logic [ADDR_W-1:0] child;
    logic              has_child;
    logic [ADDR_W-1:0] sibling;
    logic              has_sibling;
    logic [CHAR_W-1:0] ch;
  } link_t;

  // Info record of one node
  typedef struct packed {
    logic              has_info;
    logic [INFO_W-1:0] info;
  } info_t;

  // Datapath action selected by a control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_WRITE,
    ACT_ROOT_RD,
    ACT_ROOT_CHK,
    ACT_WALK_INIT,
    ACT_WALK_RD,
    ACT_WALK_CHK,
    ACT_MISS,
    ACT_HIT
  } act_t;

  // Jump condition of a control word
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_KEY,
    C_NOT_START,
    C_DEAD,
    C_HIT,
    C_LIVE
  } cond_t;

  typedef logic [3:0] upc_t;

  // Microprogram labels
  localparam upc_t PC_FETCH     = 4'd0;
  localparam upc_t PC_DISPATCH  = 4'd1;
  localparam upc_t PC_WRITE     = 4'd2;
  localparam upc_t PC_START     = 4'd3;
  localparam upc_t PC_ROOT_RD   = 4'd4;
  localparam upc_t PC_ROOT_CHK  = 4'd5;
  localparam upc_t PC_INIT      = 4'd6;
  localparam upc_t PC_WALK_RD   = 4'd7;
  localparam upc_t PC_WALK_CHK  = 4'd8;
  localparam upc_t PC_WALK_NEXT = 4'd9;
  localparam upc_t PC_MISS      = 4'd10;
  localparam upc_t PC_HIT       = 4'd11;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Status flags the sequencer branches and stalls on
  typedef struct packed {
    logic in_valid;
    logic is_key;
    logic at_start;
    logic dead;
    logic char_hit;
    logic last;
    logic out_busy;
  } dp_status_t;

  // Microprogram ROM
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      PC_FETCH:     w = '{act: ACT_FETCH,     cond: C_NEVER,     target: PC_FETCH};
      PC_DISPATCH:  w = '{act: ACT_NONE,      cond: C_KEY,       target: PC_START};
      PC_WRITE:     w = '{act: ACT_WRITE,     cond: C_ALWAYS,    target: PC_FETCH};
      PC_START:     w = '{act: ACT_NONE,      cond: C_NOT_START, target: PC_INIT};
      PC_ROOT_RD:   w = '{act: ACT_ROOT_RD,   cond: C_NEVER,     target: PC_FETCH};
      PC_ROOT_CHK:  w = '{act: ACT_ROOT_CHK,  cond: C_NEVER,     target: PC_FETCH};
      PC_INIT:      w = '{act: ACT_WALK_INIT, cond: C_DEAD,      target: PC_MISS};
      PC_WALK_RD:   w = '{act: ACT_WALK_RD,   cond: C_NEVER,     target: PC_FETCH};
      PC_WALK_CHK:  w = '{act: ACT_WALK_CHK,  cond: C_HIT,       target: PC_HIT};
      PC_WALK_NEXT: w = '{act: ACT_NONE,      cond: C_LIVE,      target: PC_WALK_RD};
      PC_MISS:      w = '{act: ACT_MISS,      cond: C_ALWAYS,    target: PC_FETCH};
      PC_HIT:       w = '{act: ACT_HIT,       cond: C_ALWAYS,    target: PC_FETCH};
      default:      w = '{act: ACT_NONE,      cond: C_ALWAYS,    target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/tkl_if.sv =====
// ----------------------------------------------------------------------------
// tkl_if
// Valid/ready channels of the trie key lookup unit: input items, results
// and root register writes.
// ----------------------------------------------------------------------------
interface tkl_item_if;
  import tkl_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] node_addr;
  logic [CHAR_W-1:0] node_char;
  logic              node_has_sibling;
  logic [ADDR_W-1:0] node_sibling;
  logic              node_has_child;
  logic [ADDR_W-1:0] node_child;
  logic              node_has_info;
  logic [INFO_W-1:0] node_info;
  logic [CHAR_W-1:0] key_char;
  logic              key_last;

  modport source (
    output valid, op, node_addr, node_char, node_has_sibling, node_sibling,
           node_has_child, node_child, node_has_info, node_info, key_char, key_last,
    input  ready
  );
  modport sink (
    input  valid, op, node_addr, node_char, node_has_sibling, node_sibling,
           node_has_child, node_child, node_has_info, node_info, key_char, key_last,
    output ready
  );
endinterface

interface tkl_result_if;
  import tkl_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [INFO_W-1:0] info_index;

  modport source (output valid, found, info_index, input ready);
  modport sink   (input valid, found, info_index, output ready);
endinterface

interface tkl_cfg_if;
  import tkl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] root_node;

  modport source (output valid, root_node, input ready);
  modport sink   (input valid, root_node, output ready);
endinterface

// ===== rtl/core/tkl_ram.sv =====
// ----------------------------------------------------------------------------
// tkl_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module tkl_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tkl_useq.sv =====
// ----------------------------------------------------------------------------
// tkl_useq
// Microsequencer: step counter, control ROM lookup, stall and
// conditional jump logic.
// ----------------------------------------------------------------------------
module tkl_useq (
  input  logic                   clk,
  input  logic                   rst,
  input  tkl_pkg::dp_status_t    status,
  output tkl_pkg::uword_t        uword
);
  import tkl_pkg::*;

  upc_t pc;
  upc_t pc_next;
  logic stall;
  logic take;

  assign uword = ucode_rom(pc);

  // Hold on a missing input word or, on the last character of a key, a full result register
  always_comb begin
    stall = 1'b0;
    if (uword.act == ACT_FETCH && !status.in_valid) begin
      stall = 1'b1;
    end
    if ((uword.act == ACT_MISS || uword.act == ACT_HIT) && status.last && status.out_busy) begin
      stall = 1'b1;
    end
  end

  // Jump condition
  always_comb begin
    unique case (uword.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_KEY:       take = status.is_key;
      C_NOT_START: take = !status.at_start;
      C_DEAD:      take = status.dead;
      C_HIT:       take = status.char_hit;
      C_LIVE:      take = !status.dead;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uword.target;
    end else begin
      pc_next = pc + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/core/tkl_dpath.sv =====
// ----------------------------------------------------------------------------
// tkl_dpath
// Datapath: input word latch, node memories, key walk registers and the
// result register, driven by one control word per cycle.
// ----------------------------------------------------------------------------
module tkl_dpath (
  input  logic                        clk,
  input  logic                        rst,
  tkl_item_if.sink                    item,
  tkl_result_if.source                result,
  input  logic [tkl_pkg::ADDR_W-1:0]  root_node,
  input  tkl_pkg::uword_t             uword,
  output tkl_pkg::dp_status_t         status
);
  import tkl_pkg::*;

  // Latched input word
  logic              op_q;
  logic [ADDR_W-1:0] node_addr_q;
  link_t             wr_link;
  info_t             wr_info;
  logic [CHAR_W-1:0] key_char_q;
  logic              key_last_q;

  // Key walk state
  logic [ADDR_W-1:0] cursor;
  logic              dead;
  logic              at_start;
  logic [ADDR_W-1:0] node;
  logic [STEP_W-1:0] steps;

  // Result register
  logic              res_valid;
  logic              res_found;
  logic [INFO_W-1:0] res_info;

  logic                    accept;
  logic                    out_busy;
  logic                    fin_act;
  logic                    fin_go;
  logic                    emit;
  logic                    char_hit;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [$bits(link_t)-1:0] link_rd_data;
  logic [$bits(info_t)-1:0] info_rd_data;
  link_t                   rd_link;
  info_t                   rd_info;

  assign item.ready = (uword.act == ACT_FETCH);
  assign accept     = item.valid && item.ready;
  assign out_busy   = res_valid && !result.ready;
  assign fin_act    = (uword.act == ACT_MISS) || (uword.act == ACT_HIT);
  assign fin_go     = fin_act && !(key_last_q && out_busy);
  assign emit       = fin_go && key_last_q;

  // Node memories
  assign rd_en   = (uword.act == ACT_ROOT_RD) || (uword.act == ACT_WALK_RD);
  assign rd_addr = (uword.act == ACT_ROOT_RD) ? root_node : node;

  tkl_ram #(.WIDTH($bits(link_t)), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk     (clk),
    .wr_en   (uword.act == ACT_WRITE),
    .wr_addr (node_addr_q),
    .wr_data (wr_link),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_rd_data)
  );

  tkl_ram #(.WIDTH($bits(info_t)), .DEPTH(NODE_COUNT)) u_info_ram (
    .clk     (clk),
    .wr_en   (uword.act == ACT_WRITE),
    .wr_addr (node_addr_q),
    .wr_data (wr_info),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (info_rd_data)
  );

  assign rd_link  = link_t'(link_rd_data);
  assign rd_info  = info_t'(info_rd_data);
  assign char_hit = (rd_link.ch == key_char_q);

  // Status to the sequencer
  always_comb begin
    status.in_valid = item.valid;
    status.is_key   = (op_q == OP_KEY);
    status.at_start = at_start;
    status.dead     = dead;
    status.char_hit = char_hit;
    status.last     = key_last_q;
    status.out_busy = out_busy;
  end

  // Key control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      dead     <= 1'b0;
      at_start <= 1'b1;
    end else begin
      unique case (uword.act)
        ACT_ROOT_RD: begin
          at_start <= 1'b0;
        end
        ACT_ROOT_CHK: begin
          if (rd_link.has_child) begin
            cursor <= rd_link.child;
          end else begin
            dead <= 1'b1;
          end
        end
        ACT_WALK_CHK: begin
          // no match and either end of chain or walk limit reached
          if (!char_hit && (!rd_link.has_sibling || steps == '1)) begin
            dead <= 1'b1;
          end
        end
        ACT_MISS, ACT_HIT: begin
          if (fin_go) begin
            if (key_last_q) begin
              cursor   <= '0;
              dead     <= 1'b0;
              at_start <= 1'b1;
            end else if (uword.act == ACT_HIT) begin
              if (rd_link.has_child) begin
                cursor <= rd_link.child;
              end else begin
                dead <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q                <= item.op;
      node_addr_q         <= item.node_addr;
      wr_link.ch          <= item.node_char;
      wr_link.has_sibling <= item.node_has_sibling;
      wr_link.sibling     <= item.node_sibling;
      wr_link.has_child   <= item.node_has_child;
      wr_link.child       <= item.node_child;
      wr_info.has_info    <= item.node_has_info;
      wr_info.info        <= item.node_info;
      key_char_q          <= item.key_char;
      key_last_q          <= item.key_last;
    end
    if (uword.act == ACT_WALK_INIT) begin
      node  <= cursor;
      steps <= '0;
    end
    if (uword.act == ACT_WALK_CHK) begin
      node  <= rd_link.sibling;
      steps <= steps + STEP_W'(1);
    end
    if (emit) begin
      res_found <= (uword.act == ACT_HIT) && rd_info.has_info;
      res_info  <= ((uword.act == ACT_HIT) && rd_info.has_info) ? rd_info.info : '0;
    end
  end

  assign result.valid      = res_valid;
  assign result.found      = res_found;
  assign result.info_index = res_info;

endmodule

// ===== rtl/core/trie_key_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// trie_key_lookup_unit
// Key lookup in a first-child / next-sibling trie held in node memory,
// controlled by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      payload
//  item     in         valid/ready    op, node_*, key_char, key_last
//  result   out        valid/ready    found, info_index
//  cfg      in         valid/ready    root_node (always ready)
//
//  One item at a time. A node write is fetched, dispatched and written. A key
//  character is fetched and dispatched, then walks its sibling chain with one
//  node memory read per node visited until a node matches, the chain ends or
//  the walk limit is reached; the first character of a key first reads the
//  root node. A dead key's character skips the walk and goes to the miss step.
//  Synchronous reset clears control state; node memory is not cleared.
//  A full result register stalls only the last character of a key.
// ----------------------------------------------------------------------------
module trie_key_lookup_unit (
  input  logic         clk,
  input  logic         rst,
  tkl_item_if.sink     item,
  tkl_result_if.source result,
  tkl_cfg_if.sink      cfg
);
  import tkl_pkg::*;

  logic [ADDR_W-1:0] root_node;
  uword_t            uword;
  dp_status_t        status;

  // Root register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= '0;
    end else if (cfg.valid) begin
      root_node <= cfg.root_node;
    end
  end

  tkl_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  tkl_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .root_node (root_node),
    .uword     (uword),
    .status    (status)
  );

endmodule

// ===== rtl/core/tkl_checker.sv =====
// ----------------------------------------------------------------------------
// tkl_checker
// Port-level checks of the trie key lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module tkl_checker (
  input logic          clk,
  input logic          rst,
  tkl_item_if.sink     item,
  tkl_result_if.source result,
  tkl_cfg_if.sink      cfg
);

  // A stalled result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid)
    else $error("result dropped while stalled");

  // A miss carries a zero info index
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.info_index == '0)
    else $error("miss with nonzero info index");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted while previous one in work");

  // A new result is never loaded in an input fetch cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!item.ready))
    else $error("result loaded during input fetch");

  // Root register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |-> cfg.ready)
    else $error("root write stalled");

endmodule

bind trie_key_lookup_unit tkl_checker u_tkl_checker (
  .clk    (clk),
  .rst    (rst),
  .item   (item),
  .result (result),
  .cfg    (cfg)
);

// ===== verif/trie_key_lookup_unit_tb.sv =====
// ----------------------------------------------------------------------------
// trie_key_lookup_unit_tb
// Self-checking bench for the trie key lookup unit. Node words and key
// characters go in over the item channel. A local copy of node memory and of
// the key cursor predicts every lookup result, and each result word is
// compared field by field in arrival order. Directed cases cover the field
// extremes, a root without a child, writes during a key and a sibling loop.
// Random phases build a small acyclic-sibling trie and walk it with real,
// bent and noise keys under random idling, one long result hold-off and a
// final stretch with no idling.
// ----------------------------------------------------------------------------
module trie_key_lookup_unit_tb;
  import tkl_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned POOL_MAX      = 64;
  localparam int unsigned HOLD_CYCLES   = 300;

  // One item channel word, packed in port order
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] node_addr;
    logic [CHAR_W-1:0] node_char;
    logic              node_has_sibling;
    logic [ADDR_W-1:0] node_sibling;
    logic              node_has_child;
    logic [ADDR_W-1:0] node_child;
    logic              node_has_info;
    logic [INFO_W-1:0] node_info;
    logic [CHAR_W-1:0] key_char;
    logic              key_last;
  } trie_word_t;

  typedef struct packed {
    logic              found;
    logic [INFO_W-1:0] info_index;
  } lookup_t;

  typedef enum {KEY_TRUE, KEY_BENT, KEY_NOISE} key_style_t;

  logic clk;
  logic rst;

  tkl_item_if   item_bus ();
  tkl_result_if result_bus ();
  tkl_cfg_if    cfg_bus ();

  trie_key_lookup_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // Predicted node memory and key state
  link_t             trie_links [NODE_COUNT];
  info_t             trie_infos [NODE_COUNT];
  logic [ADDR_W-1:0] lookup_root     = '0;
  logic [ADDR_W-1:0] lookup_cursor   = '0;
  bit                lookup_dead     = 1'b0;
  bit                lookup_at_start = 1'b1;
  lookup_t           lookups_due [$];

  // Nodes of the random trie; sibling links only point to earlier entries
  logic [ADDR_W-1:0] node_pool [$];
  bit                in_pool [NODE_COUNT];

  bit          gaps_on     = 1'b0;
  bit          stalls_on   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned fail_count  = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Advance the predicted state by one accepted word
  function automatic void lookup_word(input trie_word_t w);
    lookup_t           res;
    logic [ADDR_W-1:0] node;
    int unsigned       reads;
    bit                hit;
    if (w.op == OP_WRITE) begin
      trie_links[w.node_addr] = '{child: w.node_child, has_child: w.node_has_child,
                                  sibling: w.node_sibling,
                                  has_sibling: w.node_has_sibling, ch: w.node_char};
      trie_infos[w.node_addr] = '{has_info: w.node_has_info, info: w.node_info};
      return;
    end
    if (lookup_at_start) begin
      lookup_at_start = 1'b0;
      if (trie_links[lookup_root].has_child) lookup_cursor = trie_links[lookup_root].child;
      else lookup_dead = 1'b1;
    end
    res = '0;
    if (!lookup_dead) begin
      // sibling walk, bounded so a loop ends as a miss
      node  = lookup_cursor;
      reads = 0;
      hit   = 1'b0;
      while (reads < WALK_LIMIT && !hit) begin
        reads++;
        if (trie_links[node].ch == w.key_char) hit = 1'b1;
        else if (trie_links[node].has_sibling) node = trie_links[node].sibling;
        else reads = WALK_LIMIT;
      end
      if (!hit) begin
        lookup_dead = 1'b1;
      end else if (w.key_last) begin
        if (trie_infos[node].has_info) res = '{found: 1'b1, info_index: trie_infos[node].info};
      end else if (trie_links[node].has_child) begin
        lookup_cursor = trie_links[node].child;
      end else begin
        lookup_dead = 1'b1;
      end
    end
    if (w.key_last) begin
      lookups_due.push_back(res);
      lookup_cursor   = '0;
      lookup_dead     = 1'b0;
      lookup_at_start = 1'b1;
    end
  endfunction

  function automatic trie_word_t noise_word();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(trie_word_t)-1:0];
  endfunction

  // Offer one word, wait for acceptance, then predict
  task automatic send_word(input trie_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    {item_bus.op, item_bus.node_addr, item_bus.node_char, item_bus.node_has_sibling,
     item_bus.node_sibling, item_bus.node_has_child, item_bus.node_child,
     item_bus.node_has_info, item_bus.node_info, item_bus.key_char,
     item_bus.key_last} <= w;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    lookup_word(w);
    words_sent++;
  endtask

  task automatic write_node(input logic [ADDR_W-1:0] addr, input logic [CHAR_W-1:0] ch,
                            input bit has_sib, input logic [ADDR_W-1:0] sib,
                            input bit has_child, input logic [ADDR_W-1:0] child,
                            input bit has_info, input logic [INFO_W-1:0] info);
    trie_word_t w;
    w = noise_word();
    w.op               = OP_WRITE;
    w.node_addr        = addr;
    w.node_char        = ch;
    w.node_has_sibling = has_sib;
    w.node_sibling     = sib;
    w.node_has_child   = has_child;
    w.node_child       = child;
    w.node_has_info    = has_info;
    w.node_info        = info;
    send_word(w);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch, input bit last);
    trie_word_t w;
    w = noise_word();
    w.op       = OP_KEY;
    w.key_char = ch;
    w.key_last = last;
    send_word(w);
  endtask

  // Let every pending result drain and the sequencer settle
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_root(input logic [ADDR_W-1:0] root);
    wait_idle();
    cfg_bus.valid     <= 1'b1;
    cfg_bus.root_node <= root;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    lookup_root = root;
  endtask

  // Grow or rewrite a pool node; links stay inside the pool
  task automatic send_node_write();
    int unsigned       pos;
    int unsigned       lo;
    logic [ADDR_W-1:0] addr;
    trie_word_t        w;
    w = noise_word();
    if (node_pool.size() < 8 || (node_pool.size() < POOL_MAX && $urandom_range(0, 2) == 0)) begin
      do addr = ADDR_W'($urandom); while (in_pool[addr]);
      pos = node_pool.size();
      node_pool.push_back(addr);
      in_pool[addr] = 1'b1;
    end else begin
      pos  = $urandom_range(0, node_pool.size() - 1);
      addr = node_pool[pos];
    end
    w.op        = OP_WRITE;
    w.node_addr = addr;
    // small alphabet most of the time so chains repeat characters
    if ($urandom_range(0, 7) != 0) w.node_char = CHAR_W'(8'h61 + $urandom_range(0, 5));
    w.node_has_sibling = (pos != 0) && ($urandom_range(0, 1) == 1);
    if (w.node_has_sibling) begin
      lo = (pos > 3) ? pos - 3 : 0;
      w.node_sibling = node_pool[$urandom_range(lo, pos - 1)];
    end
    w.node_has_child = ($urandom_range(0, 3) != 0);
    if (w.node_has_child) w.node_child = node_pool[$urandom_range(0, node_pool.size() - 1)];
    send_word(w);
  endtask

  function automatic logic [ADDR_W-1:0] pick_root();
    logic [ADDR_W-1:0] cand;
    cand = node_pool[$urandom_range(0, node_pool.size() - 1)];
    for (int tries = 0; tries < 8 && !trie_links[cand].has_child; tries++)
      cand = node_pool[$urandom_range(0, node_pool.size() - 1)];
    return cand;
  endfunction

  // One key: follows the trie, follows it with one bent char, or random
  task automatic send_key(input key_style_t style);
    int unsigned       len;
    int unsigned       bend;
    int unsigned       hops;
    int unsigned       n;
    logic [ADDR_W-1:0] node;
    logic [CHAR_W-1:0] ch;
    bit                on_path;
    bit                last;
    len     = $urandom_range(1, 6);
    bend    = $urandom_range(0, len - 1);
    on_path = (style != KEY_NOISE) && trie_links[lookup_root].has_child;
    node    = trie_links[lookup_root].child;
    n       = 0;
    last    = 1'b0;
    while (!last) begin
      last = (n == len - 1);
      if (on_path) begin
        hops = $urandom_range(0, 3);
        while (hops != 0 && trie_links[node].has_sibling) begin
          node = trie_links[node].sibling;
          hops--;
        end
        ch = trie_links[node].ch;
        if (trie_links[node].has_child) begin
          node = trie_links[node].child;
        end else begin
          on_path = 1'b0;
          last    = last || ($urandom_range(0, 1) == 1);
        end
      end else if ($urandom_range(0, 1) == 1) begin
        ch = CHAR_W'(8'h61 + $urandom_range(0, 5));
      end else begin
        ch = CHAR_W'($urandom_range(0, 255));
      end
      if (style == KEY_BENT && n == bend) ch ^= CHAR_W'(1 << $urandom_range(0, 7));
      if (style != KEY_NOISE && $urandom_range(0, 19) == 0) send_node_write();
      send_char(ch, last);
      n++;
    end
  endtask

  // ---- tests ----

  // Node and info extremes, hits along a chain, two levels, dead key
  task automatic test_node_extremes();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_node(16'hFFFF, 8'h00, 1'b0, 16'hFFFF, 1'b1, 16'h0000, 1'b1, 24'h000000);
    write_node(16'h0000, 8'hFF, 1'b1, 16'h8000, 1'b0, 16'hFFFF, 1'b1, 24'hFFFFFF);
    write_node(16'h8000, 8'h41, 1'b0, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 24'h5A5A5A);
    set_root(16'hFFFF);
    send_char(8'hFF, 1'b1);
    send_char(8'h41, 1'b1);
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h55, 1'b1);
    send_char(8'h41, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // Root with no child: key is dead from its first char
  task automatic test_root_without_child();
    set_root(16'h0000);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // Writes mid-key land at once; a hit with no child kills the key
  task automatic test_write_during_key();
    set_root(16'hFFFF);
    send_char(8'h41, 1'b0);
    write_node(16'h1234, 8'h7E, 1'b1, 16'h4321, 1'b0, 16'hABCD, 1'b0, 24'h123456);
    write_node(16'hFFFF, 8'h00, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1, 24'hC0FFEE);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(8'h78, 1'b1);
  endtask

  // Two-node sibling loop: a hit inside it, then a miss at the walk bound
  task automatic test_sibling_loop();
    write_node(16'd100, 8'h01, 1'b1, 16'd101, 1'b0, 16'h0000, 1'b0, 24'h000000);
    write_node(16'd101, 8'h02, 1'b1, 16'd100, 1'b0, 16'h0000, 1'b1, 24'h0ABCDE);
    write_node(16'd200, 8'h00, 1'b0, 16'h0000, 1'b1, 16'd100, 1'b0, 24'h000000);
    set_root(16'd200);
    send_char(8'h02, 1'b1);
    send_char(8'h03, 1'b1);
  endtask

  task automatic run_lookup_phase(input int unsigned words, input bit idling);
    int unsigned stop;
    int unsigned pick;
    gaps_on   = idling;
    stalls_on = idling;
    if (node_pool.size() == 0) repeat (24) send_node_write();
    set_root(pick_root());
    stop = words_sent + words;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) send_node_write();
      else if (pick < 15) send_key(KEY_TRUE);
      else if (pick < 18) send_key(KEY_BENT);
      else send_key(KEY_NOISE);
    end
  endtask

  task automatic test_random_lookups();
    run_lookup_phase(240, 1'b1);
    run_lookup_phase(240, 1'b1);
    run_lookup_phase(240, 1'b0);
    run_lookup_phase(240, 1'b1);
  endtask

  // Result side holds off long enough for the input to stall
  task automatic test_result_backpressure();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_root(pick_root());
    hold_left = HOLD_CYCLES;
    repeat (12) send_key(KEY_TRUE);
  endtask

  task automatic test_steady_stream();
    run_lookup_phase(300, 1'b0);
  endtask

  // Result ready: random stall bursts, plus the long hold when asked
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Result checker
  initial begin
    lookup_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        if (lookups_due.size() == 0) begin
          $error("unexpected result word: found %0b info_index %06h",
                 result_bus.found, result_bus.info_index);
          fail_count++;
        end else begin
          want = lookups_due.pop_front();
          if (result_bus.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, result_bus.found);
            fail_count++;
          end
          if (result_bus.info_index !== want.info_index) begin
            $error("info_index: expected %06h, actual %06h",
                   want.info_index, result_bus.info_index);
            fail_count++;
          end
        end
      end
    end
  end

  // Sequence
  initial begin
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    {item_bus.op, item_bus.node_addr, item_bus.node_char, item_bus.node_has_sibling,
     item_bus.node_sibling, item_bus.node_has_child, item_bus.node_child,
     item_bus.node_has_info, item_bus.node_info, item_bus.key_char,
     item_bus.key_last} <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.root_node <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_node_extremes();
    test_root_without_child();
    test_write_during_key();
    test_sibling_loop();
    test_random_lookups();
    test_result_backpressure();
    test_steady_stream();

    wait_idle();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== trie_key_lookup_unit.f =====
rtl/core/tkl_pkg.sv
rtl/core/tkl_if.sv
rtl/core/tkl_ram.sv
rtl/core/tkl_useq.sv
rtl/core/tkl_dpath.sv
rtl/core/trie_key_lookup_unit.sv
rtl/core/tkl_checker.sv
verif/trie_key_lookup_unit_tb.sv
